/* src/olpd_pkg.sv */
// shared types and constants of the ordered list with positional delete
package olpd_pkg;

	// default capacity and fixed field widths
	parameter int DEPTH_DEF = 64;
	parameter int VAL_W     = 32;
	parameter int TAG_W     = 32;
	parameter int CMD_W     = 3;
	parameter int POS_W     = 7;
	parameter int CNT_W     = 7;
	parameter int WORD_W    = VAL_W + TAG_W;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DELETE_AT  = 3'd4,
		CMD_READ_AT    = 3'd5
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_NOPOS = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SHIFT  = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

endpackage

/* src/ordered_list_with_positional_delete_top.sv */
// top level of the ordered list with positional delete: sequencer, state and result register
// a delete at position p moves count - p entries through the shift state, one per cycle, and then
//   loads its result from the finish state; other commands go straight to the finish state
// items are taken one at a time (accept, then result load); out_stall holds the result load
// reset: arst_n clears the sequencer, count, front slot, tag counters and result valid;
//   the entry store is not cleared and needs no clearing pass
module ordered_list_with_positional_delete_top #(
	parameter int DEPTH = olpd_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [olpd_pkg::CMD_W-1:0]  command,
	input  logic signed [olpd_pkg::VAL_W-1:0] entry_value,
	input  logic [olpd_pkg::POS_W-1:0]  position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [olpd_pkg::CNT_W-1:0]  entry_count,
	output logic signed [olpd_pkg::VAL_W-1:0] read_value,
	output logic signed [olpd_pkg::TAG_W-1:0] read_tag
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int PW = (CW > olpd_pkg::POS_W) ? CW : olpd_pkg::POS_W;
	localparam int WW = olpd_pkg::WORD_W;
	localparam int VW = olpd_pkg::VAL_W;
	localparam int TW = olpd_pkg::TAG_W;

	// slot of an offset from the front, wrapped once around the store
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] first,
			input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(first) + SW'(off);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	olpd_pkg::state_t  state_q, state_d;
	logic [IW-1:0]     first_q, first_d, first_dec;
	logic [CW-1:0]     count_q, count_d;
	logic [TW-1:0]     ftag_q, ftag_d, btag_q, btag_d;
	logic [CW-1:0]     k_q, k_d;
	olpd_pkg::status_t res_status_q, res_status_d;
	logic [CW-1:0]     res_count_q, res_count_d;
	logic              res_rd_q, res_rd_d;

	logic              mem_we, mem_re;
	logic [IW-1:0]     mem_waddr, mem_raddr;
	logic [WW-1:0]     mem_wdata, mem_rdata;

	logic              out_load;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [olpd_pkg::CNT_W-1:0] entry_count_q;
	logic [VW-1:0]     read_value_q;
	logic [TW-1:0]     read_tag_q;

	logic [PW-1:0]     pos_ext, cnt_ext;
	logic              is_full, is_empty, bad_pos;

	// entry store
	olpd_ram #(
		.DEPTH (DEPTH),
		.WIDTH (WW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// command checks on the current state
	assign pos_ext   = PW'(position);
	assign cnt_ext   = PW'(count_q);
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign bad_pos   = (pos_ext == '0) || (pos_ext > cnt_ext);
	assign first_dec = (first_q == '0) ? IW'(DEPTH - 1) : first_q - IW'(1);

	// sequencer: next state, store access and list updates
	always_comb begin
		state_d      = state_q;
		first_d      = first_q;
		count_d      = count_q;
		ftag_d       = ftag_q;
		btag_d       = btag_q;
		k_d          = k_q;
		res_status_d = res_status_q;
		res_count_d  = res_count_q;
		res_rd_d     = res_rd_q;
		mem_we       = 1'b0;
		mem_waddr    = slot_of(first_q, k_q);
		mem_wdata    = mem_rdata;
		mem_re       = 1'b0;
		mem_raddr    = slot_of(first_q, k_q + CW'(1));
		out_load     = 1'b0;
		unique case (state_q)
			olpd_pkg::ST_IDLE: begin
				if (in_valid) begin
					res_status_d = olpd_pkg::STAT_OK;
					res_rd_d     = 1'b0;
					state_d      = olpd_pkg::ST_FINISH;
					case (command)
						olpd_pkg::CMD_PUSH_FRONT: begin
							if (is_full) begin
								res_status_d = olpd_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = first_dec;
								mem_wdata = {entry_value, ftag_q};
								first_d   = first_dec;
								ftag_d    = ftag_q + TW'(1);
								count_d   = count_q + CW'(1);
							end
						end
						olpd_pkg::CMD_PUSH_BACK: begin
							if (is_full) begin
								res_status_d = olpd_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = slot_of(first_q, count_q);
								mem_wdata = {entry_value, btag_q};
								btag_d    = btag_q - TW'(1);
								count_d   = count_q + CW'(1);
							end
						end
						olpd_pkg::CMD_POP_FRONT: begin
							if (is_empty) begin
								res_status_d = olpd_pkg::STAT_EMPTY;
							end else begin
								first_d = slot_of(first_q, CW'(1));
								count_d = count_q - CW'(1);
							end
						end
						olpd_pkg::CMD_POP_BACK: begin
							if (is_empty) begin
								res_status_d = olpd_pkg::STAT_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						olpd_pkg::CMD_DELETE_AT: begin
							if (is_empty) begin
								res_status_d = olpd_pkg::STAT_EMPTY;
							end else if (bad_pos) begin
								res_status_d = olpd_pkg::STAT_NOPOS;
							end else begin
								count_d = count_q - CW'(1);
								k_d     = CW'(pos_ext - PW'(1));
								// entries behind the gap move up one at a time
								if (pos_ext < cnt_ext) begin
									mem_re    = 1'b1;
									mem_raddr = slot_of(first_q, CW'(pos_ext));
									state_d   = olpd_pkg::ST_SHIFT;
								end
							end
						end
						olpd_pkg::CMD_READ_AT: begin
							if (is_empty) begin
								res_status_d = olpd_pkg::STAT_EMPTY;
							end else if (bad_pos) begin
								res_status_d = olpd_pkg::STAT_NOPOS;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = slot_of(first_q, CW'(pos_ext - PW'(1)));
								res_rd_d  = 1'b1;
							end
						end
						default: begin
						end
					endcase
					res_count_d = count_d;
				end
			end
			olpd_pkg::ST_SHIFT: begin
				// write the entry read last cycle one place nearer the front
				mem_we    = 1'b1;
				mem_waddr = slot_of(first_q, k_q);
				mem_wdata = mem_rdata;
				if ((k_q + CW'(1)) < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = slot_of(first_q, k_q + CW'(2));
					k_d       = k_q + CW'(1);
				end else begin
					state_d = olpd_pkg::ST_FINISH;
				end
			end
			olpd_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = olpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = olpd_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			count_q <= '0;
			ftag_q  <= TW'(1);
			btag_q  <= '1;
		end else begin
			first_q <= first_d;
			count_q <= count_d;
			ftag_q  <= ftag_d;
			btag_q  <= btag_d;
		end
	end

	// shift offset and pending result
	always_ff @(posedge clk) begin
		k_q          <= k_d;
		res_status_q <= res_status_d;
		res_count_q  <= res_count_d;
		res_rd_q     <= res_rd_d;
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= res_status_q;
			entry_count_q <= olpd_pkg::CNT_W'(res_count_q);
			read_value_q  <= res_rd_q ? mem_rdata[WW-1:TW] : '0;
			read_tag_q    <= res_rd_q ? mem_rdata[TW-1:0] : '0;
		end
	end

	assign in_stall    = (state_q != olpd_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign read_value  = read_value_q;
	assign read_tag    = read_tag_q;

`ifndef SYNTH
	// count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// shift offset stays inside the list
	a_shift_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olpd_pkg::ST_SHIFT) |-> (k_q < count_q))
		else $error("shift offset outside the list");

	// every accepted item leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != olpd_pkg::ST_IDLE))
		else $error("accepted item did not start work");

	// a new result only comes out of the finish step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == olpd_pkg::ST_FINISH))
		else $error("result raised outside finish step");
`endif

endmodule

/* src/olpd_ram.sv */
// entry store: one write port, one read port with registered read data
module olpd_ram #(
	parameter int DEPTH  = olpd_pkg::DEPTH_DEF,
	parameter int WIDTH  = olpd_pkg::WORD_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
